>>> rtl/prps_pkg.sv
// ----------------------------------------------------------------------------
// Petersen router port select package
// Shared types, register indexes, mode codes and the routing tables.
// ----------------------------------------------------------------------------
`default_nettype none

package prps_pkg;

    // Routers in one subnet and local ports per router.
    localparam int unsigned ROUTERS       = 10;
    localparam int unsigned LINKS_PER_RTR = 3;
    localparam int unsigned DEF_PORT_COUNT = 16;

    // Configuration register indexes.
    localparam logic [2:0] REG_HOSTS      = 3'd0;
    localparam logic [2:0] REG_GPORTS     = 3'd1;
    localparam logic [2:0] REG_OWN_SUBNET = 3'd2;
    localparam logic [2:0] REG_OWN_ROUTER = 3'd3;
    localparam logic [2:0] REG_NET_MODE   = 3'd4;

    // Interconnect modes; the unused code behaves like single subnet.
    localparam logic [1:0] MODE_SINGLE = 2'd0;
    localparam logic [1:0] MODE_LITE   = 2'd1;
    localparam logic [1:0] MODE_NET    = 2'd2;

    // Configuration as seen by the route logic.
    typedef struct packed {
        logic [3:0] hosts;
        logic [1:0] gports;
        logic [3:0] own_subnet;
        logic [3:0] own_router;
        logic [1:0] net_mode;
    } t_cfg;

    // One header as it enters the route logic.
    typedef struct packed {
        logic [3:0] in_port;
        logic [3:0] in_channel;
        logic [3:0] dest_subnet;
        logic [3:0] dest_rtr;
        logic [2:0] dest_host;
    } t_hdr;

    // One routing decision.
    typedef struct packed {
        logic [3:0] out_port;
        logic [3:0] out_channel;
        logic       route_error;
    } t_result;

    // Minimal routing table: local port offset from router row to router column.
    localparam logic [1:0] ROUTE_ROM [0:9][0:9] = '{
        '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2, 2'd0, 2'd2, 2'd2, 2'd1},
        '{2'd1, 2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2, 2'd0, 2'd2, 2'd2},
        '{2'd1, 2'd1, 2'd0, 2'd0, 2'd0, 2'd2, 2'd1, 2'd2, 2'd0, 2'd2},
        '{2'd0, 2'd1, 2'd1, 2'd0, 2'd0, 2'd2, 2'd2, 2'd1, 2'd2, 2'd0},
        '{2'd0, 2'd0, 2'd1, 2'd1, 2'd0, 2'd0, 2'd2, 2'd2, 2'd1, 2'd2},
        '{2'd2, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd0, 2'd1, 2'd0},
        '{2'd2, 2'd2, 2'd2, 2'd0, 2'd1, 2'd0, 2'd0, 2'd1, 2'd0, 2'd1},
        '{2'd1, 2'd2, 2'd2, 2'd2, 2'd0, 2'd1, 2'd0, 2'd0, 2'd1, 2'd0},
        '{2'd0, 2'd1, 2'd2, 2'd2, 2'd2, 2'd0, 2'd1, 2'd0, 2'd0, 2'd1},
        '{2'd2, 2'd0, 2'd1, 2'd2, 2'd2, 2'd1, 2'd0, 2'd1, 2'd0, 2'd0}
    };

    // Neighbor table: the three routers next to each router of the subnet.
    localparam logic [3:0] NBR_ROM [0:9][0:2] = '{
        '{4'd1, 4'd4, 4'd5}, '{4'd2, 4'd0, 4'd6}, '{4'd3, 4'd1, 4'd7},
        '{4'd4, 4'd2, 4'd8}, '{4'd0, 4'd3, 4'd9}, '{4'd7, 4'd8, 4'd0},
        '{4'd8, 4'd9, 4'd1}, '{4'd9, 4'd5, 4'd2}, '{4'd5, 4'd6, 4'd3},
        '{4'd6, 4'd7, 4'd4}
    };

    // Table reads that return zero for a router index outside the subnet.
    function automatic logic [1:0] route_get(input logic [3:0] src, input logic [3:0] dst);
        logic [1:0] val;
        val = 2'd0;
        if ((src < 4'(ROUTERS)) && (dst < 4'(ROUTERS))) begin
            val = ROUTE_ROM[src][dst];
        end
        return val;
    endfunction

    function automatic logic [3:0] nbr_get(input logic [3:0] rtr, input logic [1:0] idx);
        logic [3:0] val;
        val = 4'd0;
        if ((rtr < 4'(ROUTERS)) && (idx < 2'(LINKS_PER_RTR))) begin
            val = NBR_ROM[rtr][idx];
        end
        return val;
    endfunction

endpackage

`default_nettype wire

>>> rtl/prps_cfg_regs.sv
// ----------------------------------------------------------------------------
// Petersen router port select configuration registers
// Holds the five setup registers written through the plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module prps_cfg_regs (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_cfg_we,
    input  wire logic [2:0]   i_cfg_index,
    input  wire logic [3:0]   i_cfg_data,
    output prps_pkg::t_cfg    o_cfg
);
    import prps_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    // Decode the register index; writes past the last register are dropped.
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_HOSTS:      n_cfg.hosts      = i_cfg_data;
                REG_GPORTS:     n_cfg.gports     = i_cfg_data[1:0];
                REG_OWN_SUBNET: n_cfg.own_subnet = i_cfg_data;
                REG_OWN_ROUTER: n_cfg.own_router = i_cfg_data;
                REG_NET_MODE:   n_cfg.net_mode   = i_cfg_data[1:0];
                default:        n_cfg            = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.hosts      <= 4'd1;
            r_cfg.gports     <= 2'd0;
            r_cfg.own_subnet <= 4'd0;
            r_cfg.own_router <= 4'd0;
            r_cfg.net_mode   <= MODE_SINGLE;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

>>> rtl/prps_route.sv
// ----------------------------------------------------------------------------
// Petersen router port select route logic
// Picks the output port and the new virtual channel for one header.
// ----------------------------------------------------------------------------
`default_nettype none

module prps_route #(
    parameter int unsigned PORT_COUNT = prps_pkg::DEF_PORT_COUNT
) (
    input  wire prps_pkg::t_cfg    i_cfg,
    input  wire prps_pkg::t_hdr    i_hdr,
    output prps_pkg::t_result      o_result
);
    import prps_pkg::*;

    logic [4:0] w_hosts;
    logic [4:0] w_global_base;
    logic [3:0] w_mid;
    logic [3:0] w_local_dst;
    logic       w_local_ok;
    logic [4:0] w_local_port;
    logic       w_adjacent;
    logic       w_found;
    logic [1:0] w_found_idx;
    logic [3:0] w_nb;
    logic [4:0] w_nb_sub;
    logic [4:0] w_port;
    logic       w_ok;

    assign w_hosts       = {1'b0, i_cfg.hosts};
    assign w_global_base = w_hosts + 5'(LINKS_PER_RTR);

    // Subnet index with our own subnet skipped, seen as a router of this subnet.
    assign w_mid = (i_hdr.dest_subnet < i_cfg.own_subnet) ? i_hdr.dest_subnet
                                                          : i_hdr.dest_subnet - 4'd1;

    // Local port lookup; the target is the destination router inside the
    // subnet, and the forwarding router otherwise.
    assign w_local_dst  = (i_hdr.dest_subnet == i_cfg.own_subnet) ? i_hdr.dest_rtr : w_mid;
    assign w_local_ok   = (i_cfg.own_router < 4'(ROUTERS)) && (w_local_dst < 4'(ROUTERS));
    assign w_local_port = w_hosts + {3'b0, route_get(i_cfg.own_router, w_local_dst)};

    // Our router is a neighbor of the forwarding router.
    assign w_adjacent = (i_cfg.own_router < 4'(ROUTERS)) && (w_mid < 4'(ROUTERS)) &&
                        ((nbr_get(w_mid, 2'd0) == i_cfg.own_router) ||
                         (nbr_get(w_mid, 2'd1) == i_cfg.own_router) ||
                         (nbr_get(w_mid, 2'd2) == i_cfg.own_router));

    // Search the global ports for the one whose neighbor subnet is the target.
    always_comb begin
        w_found     = 1'b0;
        w_found_idx = 2'd0;
        w_nb        = 4'd0;
        w_nb_sub    = 5'd0;
        for (int i = 0; i < 3; i++) begin
            w_nb     = nbr_get(i_cfg.own_router, 2'(i));
            w_nb_sub = {1'b0, w_nb} + {4'b0, (w_nb >= i_cfg.own_subnet)};
            if (!w_found && (2'(i) < i_cfg.gports) && (w_nb_sub == {1'b0, i_hdr.dest_subnet}))
            begin
                w_found     = 1'b1;
                w_found_idx = 2'(i);
            end
        end
    end

    // Port choice by case.
    always_comb begin
        w_port = 5'd0;
        w_ok   = 1'b1;
        if (i_hdr.dest_subnet != i_cfg.own_subnet) begin
            priority if (i_cfg.net_mode == MODE_LITE) begin
                if (w_mid == i_cfg.own_router) begin
                    w_port = w_global_base;
                end else begin
                    w_port = w_local_port;
                    w_ok   = w_local_ok;
                end
            end else if (i_cfg.net_mode == MODE_NET) begin
                if (w_mid == i_cfg.own_router) begin
                    w_port = w_hosts;
                end else if (w_adjacent) begin
                    w_port = w_global_base + {3'b0, w_found_idx};
                    w_ok   = w_found;
                end else begin
                    w_port = w_local_port;
                    w_ok   = w_local_ok;
                end
            end else begin
                w_ok = 1'b0;
            end
        end else if (i_hdr.dest_rtr != i_cfg.own_router) begin
            w_port = w_local_port;
            w_ok   = w_local_ok;
        end else begin
            w_port = {2'b0, i_hdr.dest_host};
        end
    end

    // Final port check and channel update on arrival from a global port.
    always_comb begin
        o_result.route_error = !(w_ok && (int'(w_port) < int'(PORT_COUNT)));
        o_result.out_port    = o_result.route_error ? 4'd0 : w_port[3:0];
        if (({1'b0, i_hdr.in_port} >= w_global_base) && (i_hdr.in_channel != 4'hF)) begin
            o_result.out_channel = i_hdr.in_channel + 4'd1;
        end else begin
            o_result.out_channel = i_hdr.in_channel;
        end
    end

endmodule

`default_nettype wire

>>> rtl/petersen_router_port_select_top.sv
// ----------------------------------------------------------------------------
// Petersen router port select top level
// Route stage for one router of a ten-router Petersen-graph subnet.
// ----------------------------------------------------------------------------
// The block takes one header beat per clock cycle while the result side is
// not stalled. The header is captured in an input register when it is
// accepted, the table lookups and compares run in one pass of logic, and the
// decision is loaded into an output register when that stage is free, and is
// shown on the result side from there. The two registers advance on their
// own, a full pipeline moves one beat every cycle while results are taken,
// and a stall on the result side backs up through the two stages before the
// header side sees ready drop. Configuration is to be written through the
// plain write port while the block is idle; the block does not enforce it.
`default_nettype none

module petersen_router_port_select_top #(
    parameter int unsigned PORT_COUNT = prps_pkg::DEF_PORT_COUNT
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [2:0] i_cfg_index,
    input  wire logic [3:0] i_cfg_data,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [3:0] i_in_port,
    input  wire logic [3:0] i_in_channel,
    input  wire logic [3:0] i_dest_subnet,
    input  wire logic [3:0] i_dest_router,
    input  wire logic [2:0] i_dest_host,
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic [3:0]      o_next_port,
    output logic [3:0]      o_out_channel,
    output logic            o_route_error
);
    import prps_pkg::*;

    t_cfg    w_cfg;
    t_hdr    r_hdr;
    t_result w_result;
    t_result r_result;
    logic    r_in_valid;
    logic    r_out_valid;
    logic    w_out_free;
    logic    w_in_free;

    prps_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    prps_route #(
        .PORT_COUNT (PORT_COUNT)
    ) u_route (
        .i_cfg    (w_cfg),
        .i_hdr    (r_hdr),
        .o_result (w_result)
    );

    // A stage can load when it is empty or its beat leaves this cycle.
    assign w_out_free = !r_out_valid || i_ready;
    assign w_in_free  = !r_in_valid || w_out_free;
    assign o_ready    = w_in_free;

    // Valid bits of the two stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_free) begin
                r_in_valid <= i_valid;
            end
            if (w_out_free) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    // Header and result payload registers.
    always_ff @(posedge i_clk) begin
        if (w_in_free && i_valid) begin
            r_hdr.in_port     <= i_in_port;
            r_hdr.in_channel  <= i_in_channel;
            r_hdr.dest_subnet <= i_dest_subnet;
            r_hdr.dest_rtr    <= i_dest_router;
            r_hdr.dest_host   <= i_dest_host;
        end
        if (w_out_free && r_in_valid) begin
            r_result <= w_result;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_next_port   = r_result.out_port;
    assign o_out_channel = r_result.out_channel;
    assign o_route_error = r_result.route_error;

endmodule

`default_nettype wire

>>> rtl/prps_checker.sv
// ----------------------------------------------------------------------------
// Petersen router port select checker
// Port-level assertions on the top level, attached by a bind statement.
// ----------------------------------------------------------------------------
`default_nettype none

module prps_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_valid,
    input wire logic       o_ready,
    input wire logic [3:0] i_in_port,
    input wire logic [3:0] i_in_channel,
    input wire logic [3:0] i_dest_subnet,
    input wire logic [3:0] i_dest_router,
    input wire logic [2:0] i_dest_host,
    input wire logic       o_valid,
    input wire logic       i_ready,
    input wire logic [3:0] o_next_port,
    input wire logic [3:0] o_out_channel,
    input wire logic       o_route_error
);

    // A waiting header beat stays presented and unchanged until it is taken.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_ready) |=> (i_valid && $stable(i_in_port) &&
                                   $stable(i_in_channel) && $stable(i_dest_subnet) &&
                                   $stable(i_dest_router) && $stable(i_dest_host)))
        else $error("header beat changed while stalled");

    // A stalled result beat holds its value until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_next_port) &&
                                   $stable(o_out_channel) && $stable(o_route_error)))
        else $error("result beat changed while stalled");

    // An error result always carries port zero.
    a_error_port: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_route_error) |-> (o_next_port == 4'd0))
        else $error("error result with nonzero port");

    // Reset empties the pipeline and opens the header side.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_valid && o_ready))
        else $error("pipeline not empty after reset");

    // With no result waiting the header side is never held off.
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("header side stalled with empty output");

endmodule

bind petersen_router_port_select_top prps_checker u_prps_checker (.*);

`default_nettype wire

>>> tb/sv/petersen_router_port_select_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Petersen router port select testbench
// Drives header beats through the route stage under random idling on both
// sides and checks every routing decision against a predictor of the block.
// ----------------------------------------------------------------------------
`default_nettype none

module petersen_router_port_select_top_tb;

    import prps_pkg::*;

    localparam int unsigned PORTS       = 16;
    localparam int unsigned CYCLE_LIMIT = 300000;
    localparam int unsigned IDLE_CYCLES = 4;
    localparam int unsigned HOP_PHASES  = 30;
    localparam int unsigned HOP_BEATS   = 20;

    // The fourth mode code has no name in the package; it acts as single subnet.
    localparam logic [1:0] MODE_SPARE = 2'd3;

    // Local port offset from the router of the row toward the router of the column.
    localparam bit [1:0] HOP_TBL [0:9][0:9] = '{
        '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2, 2'd0, 2'd2, 2'd2, 2'd1},
        '{2'd1, 2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2, 2'd0, 2'd2, 2'd2},
        '{2'd1, 2'd1, 2'd0, 2'd0, 2'd0, 2'd2, 2'd1, 2'd2, 2'd0, 2'd2},
        '{2'd0, 2'd1, 2'd1, 2'd0, 2'd0, 2'd2, 2'd2, 2'd1, 2'd2, 2'd0},
        '{2'd0, 2'd0, 2'd1, 2'd1, 2'd0, 2'd0, 2'd2, 2'd2, 2'd1, 2'd2},
        '{2'd2, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd0, 2'd1, 2'd0},
        '{2'd2, 2'd2, 2'd2, 2'd0, 2'd1, 2'd0, 2'd0, 2'd1, 2'd0, 2'd1},
        '{2'd1, 2'd2, 2'd2, 2'd2, 2'd0, 2'd1, 2'd0, 2'd0, 2'd1, 2'd0},
        '{2'd0, 2'd1, 2'd2, 2'd2, 2'd2, 2'd0, 2'd1, 2'd0, 2'd0, 2'd1},
        '{2'd2, 2'd0, 2'd1, 2'd2, 2'd2, 2'd1, 2'd0, 2'd1, 2'd0, 2'd0}
    };

    // The three routers wired to each router of the subnet.
    localparam bit [3:0] NBR_TBL [0:9][0:2] = '{
        '{4'd1, 4'd4, 4'd5}, '{4'd2, 4'd0, 4'd6}, '{4'd3, 4'd1, 4'd7},
        '{4'd4, 4'd2, 4'd8}, '{4'd0, 4'd3, 4'd9}, '{4'd7, 4'd8, 4'd0},
        '{4'd8, 4'd9, 4'd1}, '{4'd9, 4'd5, 4'd2}, '{4'd5, 4'd6, 4'd3},
        '{4'd6, 4'd7, 4'd4}
    };

    // Block ports.
    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       i_cfg_we      = 1'b0;
    logic [2:0] i_cfg_index   = '0;
    logic [3:0] i_cfg_data    = '0;
    logic       i_valid       = 1'b0;
    logic       o_ready;
    logic [3:0] i_in_port     = '0;
    logic [3:0] i_in_channel  = '0;
    logic [3:0] i_dest_subnet = '0;
    logic [3:0] i_dest_router = '0;
    logic [2:0] i_dest_host   = '0;
    logic       o_valid;
    logic       i_ready       = 1'b0;
    logic [3:0] o_next_port;
    logic [3:0] o_out_channel;
    logic       o_route_error;

    // Register contents as the block should hold them.
    logic [3:0] cfg_hosts  = 4'd1;
    logic [1:0] cfg_gports = 2'd0;
    logic [3:0] cfg_subnet = 4'd0;
    logic [3:0] cfg_router = 4'd0;
    logic [1:0] cfg_mode   = MODE_SINGLE;

    // Headers waiting to be sent and decisions waiting to come back.
    t_hdr        hdr_pending [$];
    t_result     route_expect [$];
    int unsigned n_queued    = 0;
    int unsigned n_accepted  = 0;
    int unsigned n_decisions = 0;
    int unsigned fault_count = 0;
    int unsigned tx_gap_max  = 8;
    int unsigned rx_gap_max  = 8;
    int unsigned tx_hold     = 0;
    int unsigned rx_hold     = 0;

    petersen_router_port_select_top #(
        .PORT_COUNT(PORTS)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_in_port    (i_in_port),
        .i_in_channel (i_in_channel),
        .i_dest_subnet(i_dest_subnet),
        .i_dest_router(i_dest_router),
        .i_dest_host  (i_dest_host),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_next_port  (o_next_port),
        .o_out_channel(o_out_channel),
        .o_route_error(o_route_error)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Local port toward router dst; fails when either router index is off the table.
    function automatic bit hop_port(input int unsigned dst, output int unsigned port);
        port = 0;
        if (cfg_router >= 4'd10 || dst >= 10) begin
            return 1'b0;
        end
        port = cfg_hosts + HOP_TBL[cfg_router][dst];
        return 1'b1;
    endfunction

    // True when router a sits next to router b.
    function automatic bit adj_to(input int unsigned a, input int unsigned b);
        bit found;
        found = 1'b0;
        if (b < 10) begin
            for (int k = 0; k < 3; k++) begin
                if (NBR_TBL[b][k] == a) begin
                    found = 1'b1;
                end
            end
        end
        return found;
    endfunction

    // Routing decision for one header under the current register settings.
    function automatic t_result predict_route(input t_hdr h);
        t_result     r;
        int unsigned chan;
        int unsigned dsub;
        int unsigned mid;
        int unsigned port;
        int unsigned nb;
        bit          ok;
        chan = h.in_channel;
        dsub = h.dest_subnet;
        port = 0;
        ok   = 1'b1;
        // Arrival on a global port moves the packet up one channel.
        if (h.in_port >= cfg_hosts + 3 && chan < 15) begin
            chan++;
        end
        if (dsub != cfg_subnet) begin
            if (cfg_mode != MODE_LITE && cfg_mode != MODE_NET) begin
                ok = 1'b0;
            end else begin
                // Subnet index with this subnet skipped gives the gateway router.
                mid = (dsub < cfg_subnet) ? dsub : dsub - 1;
                if (mid == cfg_router) begin
                    port = (cfg_mode == MODE_LITE) ? cfg_hosts + 3 : cfg_hosts;
                end else if (cfg_mode == MODE_NET && cfg_router < 4'd10
                             && adj_to(cfg_router, mid)) begin
                    // Search the global ports for one that leads straight there.
                    ok = 1'b0;
                    for (int k = 0; k < 3; k++) begin
                        if (k < cfg_gports && !ok) begin
                            nb = NBR_TBL[cfg_router][k];
                            if (nb >= cfg_subnet) begin
                                nb++;
                            end
                            if (nb == dsub) begin
                                port = cfg_hosts + 3 + k;
                                ok   = 1'b1;
                            end
                        end
                    end
                end else begin
                    ok = hop_port(mid, port);
                end
            end
        end else if (h.dest_rtr != cfg_router) begin
            ok = hop_port(h.dest_rtr, port);
        end else begin
            port = h.dest_host;
        end
        if (ok && port >= PORTS) begin
            ok = 1'b0;
        end
        if (!ok) begin
            port = 0;
        end
        r.out_port    = port[3:0];
        r.out_channel = chan[3:0];
        r.route_error = !ok;
        return r;
    endfunction

    // Sender: presents queued headers, with a random hold-off after each beat.
    always @(posedge i_clk) begin
        t_hdr h;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            tx_hold = 0;
        end else begin
            if (i_valid && o_ready) begin
                h.in_port     = i_in_port;
                h.in_channel  = i_in_channel;
                h.dest_subnet = i_dest_subnet;
                h.dest_rtr    = i_dest_router;
                h.dest_host   = i_dest_host;
                route_expect = {route_expect, predict_route(h)};
                n_accepted++;
            end
            if (!i_valid || o_ready) begin
                if (tx_hold > 0) begin
                    tx_hold--;
                    i_valid <= 1'b0;
                end else if (hdr_pending.size() > 0) begin
                    h = hdr_pending.pop_front();
                    i_in_port     <= h.in_port;
                    i_in_channel  <= h.in_channel;
                    i_dest_subnet <= h.dest_subnet;
                    i_dest_router <= h.dest_rtr;
                    i_dest_host   <= h.dest_host;
                    i_valid       <= 1'b1;
                    tx_hold = $urandom_range(0, tx_gap_max);
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks each decision beat and stalls at random afterwards.
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            rx_hold = 0;
        end else begin
            if (o_valid && i_ready) begin
                n_decisions++;
                if (route_expect.size() == 0) begin
                    fault_count++;
                    if (fault_count <= 10) begin
                        $display("decision %0d: no header outstanding (%0d %0d %0d)",
                                 n_decisions, o_next_port, o_out_channel, o_route_error);
                    end
                end else begin
                    want = route_expect.pop_front();
                    if (o_next_port !== want.out_port || o_out_channel !== want.out_channel
                        || o_route_error !== want.route_error) begin
                        fault_count++;
                        if (fault_count <= 10) begin
                            $display("decision %0d: want %0d %0d %0d, got %0d %0d %0d",
                                     n_decisions, want.out_port, want.out_channel,
                                     want.route_error, o_next_port, o_out_channel,
                                     o_route_error);
                        end
                    end
                end
                rx_hold = $urandom_range(0, rx_gap_max);
            end
            if (rx_hold > 0) begin
                rx_hold--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // Wait until every queued header has been decided, then let the pipe drain.
    task automatic wait_idle();
        while (n_accepted != n_queued || route_expect.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (IDLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [3:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
    endtask

    // Program all five registers once the block has gone quiet.
    task automatic apply_cfg(input logic [3:0] hosts, input logic [1:0] gports,
                             input logic [3:0] subnet, input logic [3:0] router,
                             input logic [1:0] mode);
        wait_idle();
        write_reg(REG_HOSTS, hosts);
        write_reg(REG_GPORTS, {2'b00, gports});
        write_reg(REG_OWN_SUBNET, subnet);
        write_reg(REG_OWN_ROUTER, router);
        write_reg(REG_NET_MODE, {2'b00, mode});
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        cfg_hosts  = hosts;
        cfg_gports = gports;
        cfg_subnet = subnet;
        cfg_router = router;
        cfg_mode   = mode;
    endtask

    task automatic add_hdr(input int unsigned port, input int unsigned chan,
                           input int unsigned dsub, input int unsigned drtr,
                           input int unsigned dhost);
        t_hdr h;
        h.in_port     = port[3:0];
        h.in_channel  = chan[3:0];
        h.dest_subnet = dsub[3:0];
        h.dest_rtr    = drtr[3:0];
        h.dest_host   = dhost[2:0];
        hdr_pending = {hdr_pending, h};
        n_queued++;
    endtask

    // Run watchdog.
    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("[petersen_router_port_select_top] ERROR");
        $finish;
    end

    initial begin
        t_hdr        h;
        logic [3:0]  hosts;
        logic [1:0]  gports;
        logic [3:0]  subnet;
        logic [3:0]  router;
        logic [1:0]  mode;
        int unsigned pick;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Fishnet with all global ports: delivery, hops, gateway and every global hit.
        apply_cfg(4'd2, 2'd3, 4'd4, 4'd0, MODE_NET);
        add_hdr(15, 15, 4, 0, 7);
        add_hdr(0, 0, 4, 9, 0);
        add_hdr(4, 14, 4, 15, 3);
        add_hdr(5, 14, 0, 0, 0);
        add_hdr(1, 3, 2, 5, 1);
        add_hdr(2, 7, 1, 0, 5);
        add_hdr(6, 8, 6, 3, 2);
        add_hdr(3, 1, 5, 9, 6);
        add_hdr(7, 2, 15, 15, 7);
        add_hdr(8, 0, 3, 0, 0);

        // One global port only: the neighbor behind the second port is missed.
        apply_cfg(4'd2, 2'd1, 4'd4, 4'd0, MODE_NET);
        add_hdr(0, 5, 5, 0, 0);
        add_hdr(9, 15, 1, 2, 4);

        // Fish-lite at the top subnet index.
        apply_cfg(4'd8, 2'd1, 4'd10, 4'd3, MODE_LITE);
        add_hdr(11, 6, 3, 0, 0);
        add_hdr(10, 9, 0, 2, 1);
        add_hdr(12, 4, 11, 0, 2);
        add_hdr(0, 15, 10, 3, 0);

        // Router index off the table and a gateway port beyond the port count.
        apply_cfg(4'd15, 2'd3, 4'd0, 4'd12, MODE_LITE);
        add_hdr(15, 10, 13, 0, 0);
        add_hdr(14, 3, 1, 0, 0);
        add_hdr(0, 0, 0, 5, 7);
        add_hdr(3, 1, 0, 12, 3);

        // Unused mode code and single subnet both refuse other subnets.
        apply_cfg(4'd1, 2'd2, 4'd3, 4'd5, MODE_SPARE);
        add_hdr(4, 12, 7, 5, 2);
        add_hdr(3, 13, 3, 1, 0);
        apply_cfg(4'd1, 2'd0, 4'd0, 4'd0, MODE_SINGLE);
        add_hdr(1, 2, 9, 9, 1);
        add_hdr(0, 0, 0, 0, 0);

        // Random phases; the first two sit at the low and high ends of the normal ranges.
        for (int p = 0; p < HOP_PHASES; p++) begin
            if (p == 0) begin
                hosts = 4'd1; gports = 2'd0; subnet = 4'd0; router = 4'd0; mode = MODE_SINGLE;
            end else if (p == 1) begin
                hosts = 4'd8; gports = 2'd3; subnet = 4'd10; router = 4'd9; mode = MODE_NET;
            end else begin
                pick   = $urandom_range(0, 9);
                hosts  = (pick == 0) ? 4'd15 : (pick == 1) ? 4'd0 : 4'($urandom_range(1, 8));
                gports = 2'($urandom_range(0, 3));
                subnet = ($urandom_range(0, 9) == 0) ? 4'd15 : 4'($urandom_range(0, 10));
                router = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(10, 15))
                                                    : 4'($urandom_range(0, 9));
                pick   = $urandom_range(0, 9);
                case (pick)
                    0, 1:       mode = MODE_SINGLE;
                    2, 3, 4:    mode = MODE_LITE;
                    9:          mode = MODE_SPARE;
                    default:    mode = MODE_NET;
                endcase
            end
            apply_cfg(hosts, gports, subnet, router, mode);
            // Some phases run back to back on one side or both.
            tx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 8;
            rx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 8;
            for (int n = 0; n < HOP_BEATS; n++) begin
                h.in_port    = 4'($urandom_range(0, 15));
                h.in_channel = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(13, 15))
                                                          : 4'($urandom_range(0, 15));
                pick = $urandom_range(0, 9);
                if (pick < 4) begin
                    h.dest_subnet = cfg_subnet;
                end else if (pick == 9) begin
                    h.dest_subnet = 4'($urandom_range(0, 15));
                end else begin
                    h.dest_subnet = 4'($urandom_range(0, 10));
                end
                pick = $urandom_range(0, 7);
                if (pick == 0) begin
                    h.dest_rtr = 4'($urandom_range(0, 15));
                end else if (pick < 3) begin
                    h.dest_rtr = cfg_router;
                end else begin
                    h.dest_rtr = 4'($urandom_range(0, 9));
                end
                h.dest_host = 3'($urandom_range(0, 7));
                hdr_pending = {hdr_pending, h};
                n_queued++;
            end
        end

        wait_idle();
        if (fault_count == 0) begin
            $display("[petersen_router_port_select_top] OK");
        end else begin
            $display("[petersen_router_port_select_top] ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
